// ===== sv/csx_pkg.sv =====
// ----------------------------------------------------------------------------
// csx_pkg
// Shared types and constants for the chunk-seeded xoshiro256++ stream core.
// ----------------------------------------------------------------------------
package csx_pkg;

  localparam logic [63:0] KEY_LOW_RST  = 64'h243f6a8885a308d3;
  localparam logic [63:0] KEY_HIGH_RST = 64'h13198a2e03707344;
  localparam logic [63:0] PH_M0 = 64'hD2E7470EE14C6C93;
  localparam logic [63:0] PH_M1 = 64'hCA5A826395121157;
  localparam logic [63:0] PH_W0 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] PH_W1 = 64'hBB67AE8584CAA73B;

  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  // Datapath operation codes
  typedef enum logic [2:0] {
    OP_NONE,     // hold
    OP_SEED_NEW, // load counter with chunk, reset key schedule
    OP_MUL,      // capture partial products for one Philox round
    OP_ROUND,    // finish one Philox round
    OP_LOAD,     // move Philox result into generator state
    OP_STEP      // emit a word and advance the generator
  } csx_op_t;

  typedef struct packed {
    csx_op_t     op;
    logic        use_start; // seed from start_chunk instead of current+1/current
    logic        first;     // first round: key not yet bumped
  } csx_cmd_t;

  typedef struct packed {
    logic last; // word position at end of chunk
  } csx_sts_t;

endpackage

// ===== sv/csx_if.sv =====
// ----------------------------------------------------------------------------
// csx_in_if / csx_out_if
// Valid/ready channels for requests and result words.
// ----------------------------------------------------------------------------
interface csx_in_if;
  logic        valid;
  logic        ready;
  logic        restart;
  logic [63:0] start_chunk;
  modport source (output valid, restart, start_chunk, input ready);
  modport sink   (input valid, restart, start_chunk, output ready);
endinterface

interface csx_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] word;
  logic [63:0] chunk_number;
  logic        last_in_chunk;
  modport source (output valid, word, chunk_number, last_in_chunk, input ready);
  modport sink   (input valid, word, chunk_number, last_in_chunk, output ready);
endinterface

// ===== sv/csx_datapath.sv =====
// ----------------------------------------------------------------------------
// csx_datapath
// Philox4x64 round unit (a multiply step then a round step, 32x32 partial products),
// xoshiro256++ state, chunk counter and word position.
// ----------------------------------------------------------------------------
module csx_datapath
  import csx_pkg::*;
#(
  parameter int WORDS_PER_CHUNK = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  csx_cmd_t    cmd,
  output csx_sts_t    sts,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic [63:0] start_chunk,
  output logic [63:0] word,
  output logic [63:0] chunk_number,
  output logic        last_in_chunk
);

  localparam int PW = (WORDS_PER_CHUNK > 1) ? $clog2(WORDS_PER_CHUNK) : 1;
  localparam logic [PW-1:0] POS_LAST = PW'(WORDS_PER_CHUNK - 1);

  logic [63:0] x_r [4];
  logic [63:0] s_r [4];
  logic [63:0] k0_r, k1_r;
  logic [63:0] chunk_r;
  logic [PW-1:0] pos_r;
  // partial products of the two 64x64 multiplies
  logic [63:0] pa_r [4];
  logic [63:0] pb_r [4];

  logic [63:0] seed_chunk;
  logic [63:0] h0, l0, h1, l1;
  logic [63:0] k0_use, k1_use;
  logic [63:0] w, t;
  logic [63:0] n0, n1, n2, n3;

  // 128-bit product from four 32x32 partials
  function automatic logic [127:0] join_pp(input logic [63:0] p00, input logic [63:0] p01,
                                           input logic [63:0] p10, input logic [63:0] p11);
    logic [127:0] r;
    r = {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
    return r;
  endfunction

  assign sts.last = (pos_r == POS_LAST);
  assign seed_chunk = cmd.use_start ? start_chunk : chunk_r;
  assign {h0, l0} = join_pp(pa_r[0], pa_r[1], pa_r[2], pa_r[3]);
  assign {h1, l1} = join_pp(pb_r[0], pb_r[1], pb_r[2], pb_r[3]);
  assign k0_use = cmd.first ? k0_r : k0_r + PH_W0;
  assign k1_use = cmd.first ? k1_r : k1_r + PH_W1;

  // xoshiro256++ step
  assign w  = {s_r[0] + s_r[3]} << 23 | (s_r[0] + s_r[3]) >> 41;
  assign t  = s_r[1] << 17;
  assign n2 = s_r[2] ^ s_r[0];
  assign n3 = s_r[3] ^ s_r[1];
  assign n1 = s_r[1] ^ n2;
  assign n0 = s_r[0] ^ n3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= '0;
      pos_r   <= '0;
    end else begin
      unique case (cmd.op)
        OP_SEED_NEW: begin
          x_r[0] <= seed_chunk;
          x_r[1] <= '0;
          x_r[2] <= 64'd1;
          x_r[3] <= '0;
          k0_r   <= key_low;
          k1_r   <= key_high;
          chunk_r <= seed_chunk;
          pos_r  <= '0;
        end
        OP_MUL: begin
          pa_r[0] <= 64'(PH_M0[31:0])  * 64'(x_r[0][31:0]);
          pa_r[1] <= 64'(PH_M0[31:0])  * 64'(x_r[0][63:32]);
          pa_r[2] <= 64'(PH_M0[63:32]) * 64'(x_r[0][31:0]);
          pa_r[3] <= 64'(PH_M0[63:32]) * 64'(x_r[0][63:32]);
          pb_r[0] <= 64'(PH_M1[31:0])  * 64'(x_r[2][31:0]);
          pb_r[1] <= 64'(PH_M1[31:0])  * 64'(x_r[2][63:32]);
          pb_r[2] <= 64'(PH_M1[63:32]) * 64'(x_r[2][31:0]);
          pb_r[3] <= 64'(PH_M1[63:32]) * 64'(x_r[2][63:32]);
        end
        OP_ROUND: begin
          x_r[0] <= h1 ^ x_r[1] ^ k0_use;
          x_r[1] <= l1;
          x_r[2] <= h0 ^ x_r[3] ^ k1_use;
          x_r[3] <= l0;
          k0_r   <= k0_use;
          k1_r   <= k1_use;
        end
        OP_LOAD: begin
          s_r[0] <= ((x_r[0] | x_r[1] | x_r[2] | x_r[3]) == '0) ? 64'd1 : x_r[0];
          s_r[1] <= x_r[1];
          s_r[2] <= x_r[2];
          s_r[3] <= x_r[3];
        end
        OP_STEP: begin
          word          <= w + s_r[0];
          chunk_number  <= chunk_r;
          last_in_chunk <= sts.last;
          s_r[0] <= n0;
          s_r[1] <= n1;
          s_r[2] <= n2 ^ t;
          s_r[3] <= {n3[18:0], n3[63:19]};
          if (sts.last) begin
            chunk_r <= chunk_r + 64'd1;
            pos_r   <= '0;
          end else begin
            pos_r <= pos_r + PW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/csx_ctrl.sv =====
// ----------------------------------------------------------------------------
// csx_ctrl
// Sequencer: reset seeding, restart seeding, word steps, chunk reseeding.
// ----------------------------------------------------------------------------
module csx_ctrl
  import csx_pkg::*;
#(
  parameter int PHILOX_ROUNDS = 10
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_restart,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  csx_sts_t sts,
  output csx_cmd_t cmd
);

  localparam int RW = $clog2(PHILOX_ROUNDS + 1);

  typedef enum logic [2:0] {
    S_SEED, S_MUL, S_ROUND, S_LOAD, S_RUN, S_STEP, S_HOLD
  } state_t;

  state_t        state_r;
  logic [RW-1:0] rnd_r;
  logic          fresh_r;   // restart taken, step follows seeding
  logic          use_st_r;
  logic          out_v_r;
  logic          take;
  logic          can_step;

  assign can_step  = !out_v_r || out_ready;
  assign in_ready  = (state_r == S_RUN) && can_step;
  assign take      = in_valid && in_ready;
  assign out_valid = out_v_r;

  always_comb begin
    cmd = '{op: OP_NONE, use_start: use_st_r, first: (rnd_r == '0)};
    unique case (state_r)
      S_SEED:  cmd.op = OP_SEED_NEW;
      S_MUL:   cmd.op = OP_MUL;
      S_ROUND: cmd.op = OP_ROUND;
      S_LOAD:  cmd.op = OP_LOAD;
      S_RUN: begin
        if (take && !in_restart) cmd.op = OP_STEP;
        if (take && in_restart) begin
          cmd.op = OP_SEED_NEW;
          cmd.use_start = 1'b1;
        end
      end
      S_STEP:  cmd.op = can_step ? OP_STEP : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_SEED;
      rnd_r    <= '0;
      fresh_r  <= 1'b0;
      use_st_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      // a step refills the result register in the same cycle it drains
      if (out_v_r && out_ready && (cmd.op != OP_STEP)) out_v_r <= 1'b0;
      unique case (state_r)
        S_SEED: begin
          use_st_r <= 1'b0;
          rnd_r    <= '0;
          state_r  <= S_MUL;
        end
        S_MUL: state_r <= S_ROUND;
        S_ROUND: begin
          rnd_r   <= rnd_r + RW'(1);
          state_r <= (rnd_r == RW'(PHILOX_ROUNDS - 1)) ? S_LOAD : S_MUL;
        end
        S_LOAD: begin
          state_r <= fresh_r ? S_STEP : S_RUN;
          fresh_r <= 1'b0;
        end
        S_RUN: begin
          if (take) begin
            if (in_restart) begin
              fresh_r <= 1'b1;
              rnd_r   <= '0;
              state_r <= S_MUL;
            end else begin
              out_v_r <= 1'b1;
              if (sts.last) state_r <= S_SEED;
            end
          end
        end
        S_STEP: begin
          if (can_step) begin
            out_v_r <= 1'b1;
            state_r <= sts.last ? S_SEED : S_RUN;
          end
        end
        default: state_r <= S_SEED;
      endcase
    end
  end

endmodule

// ===== sv/chunk_seeded_xoshiro_stream_core.sv =====
// ----------------------------------------------------------------------------
// chunk_seeded_xoshiro_stream_core
// xoshiro256++ word stream, reseeded each chunk by Philox4x64 on a key.
// ----------------------------------------------------------------------------
//  channel | dir | transfer moves
//  in_     | in  | restart, start_chunk
//  out_    | out | word, chunk_number, last_in_chunk
//  cfg_    | in  | key_low (index 0), key_high (index 1)
//
// Inside a chunk requests are stepped into out_ back to back. Seeding
// (after reset, after the last word of a chunk, on a restart) runs the Philox
// round unit as a multiply step then a round step per round, with in_ready low.
// Reset is synchronous; the first request is taken once chunk zero is seeded.
// A stalled result holds out_ and blocks the next request only.
module chunk_seeded_xoshiro_stream_core
  import csx_pkg::*;
#(
  parameter int WORDS_PER_CHUNK = 512,
  parameter int PHILOX_ROUNDS   = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  csx_in_if.sink      in_ch,
  csx_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] key_low_r, key_high_r;
  csx_cmd_t    cmd;
  csx_sts_t    sts;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= KEY_LOW_RST;
      key_high_r <= KEY_HIGH_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_KEY_LOW)  key_low_r  <= cfg_wdata;
      if (cfg_index == CFG_KEY_HIGH) key_high_r <= cfg_wdata;
    end
  end

  csx_ctrl #(.PHILOX_ROUNDS(PHILOX_ROUNDS)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_restart(in_ch.restart), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  csx_datapath #(.WORDS_PER_CHUNK(WORDS_PER_CHUNK)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .key_low(key_low_r), .key_high(key_high_r),
    .start_chunk(in_ch.start_chunk),
    .word(out_ch.word), .chunk_number(out_ch.chunk_number),
    .last_in_chunk(out_ch.last_in_chunk)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the chunk-seeded xoshiro256++ stream core. A directed table and
// random restart/continue segments are driven over valid/ready. Each result
// is checked against an in-bench Philox4x64 seeder and xoshiro256++ stepper,
// with random idling on both sides, a long output stall and key changes.
// ----------------------------------------------------------------------------
module tb_top;
  import csx_pkg::*;

  localparam int WORDS_PER_CHUNK = 512;
  localparam int PHILOX_ROUNDS   = 10;
  localparam int SEED_SETTLE     = 2 * PHILOX_ROUNDS + 10;

  typedef struct packed {
    logic [63:0] word;
    logic [63:0] chunk_number;
    logic        last_in_chunk;
  } word_rec_t;

  typedef struct packed {
    logic        restart;
    logic [63:0] start_chunk;
    logic        typed;      // chunk/last typed in below
    logic [63:0] exp_chunk;
    logic        exp_last;
  } req_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;

  csx_in_if  in_ch ();
  csx_out_if out_ch ();

  chunk_seeded_xoshiro_stream_core #(
    .WORDS_PER_CHUNK(WORDS_PER_CHUNK),
    .PHILOX_ROUNDS  (PHILOX_ROUNDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  logic [63:0] key_lo, key_hi;
  logic [63:0] xs [4];
  int unsigned pos;
  logic [63:0] cur_chunk;

  word_rec_t   pending_words[$];
  int          mismatches;
  bit          quiet;
  int          hold_left;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Philox4x64 seed of one chunk under the current key
  task automatic seed_chunk(input logic [63:0] chunk);
    logic [63:0]  x0, x1, x2, x3, k0, k1;
    logic [127:0] p0, p1;
    x0 = chunk; x1 = 64'd0; x2 = 64'd1; x3 = 64'd0;
    k0 = key_lo; k1 = key_hi;
    for (int r = 0; r < PHILOX_ROUNDS; r++) begin
      if (r > 0) begin
        k0 = k0 + PH_W0;
        k1 = k1 + PH_W1;
      end
      p0 = {64'd0, PH_M0} * {64'd0, x0};
      p1 = {64'd0, PH_M1} * {64'd0, x2};
      x0 = p1[127:64] ^ x1 ^ k0;
      x2 = p0[127:64] ^ x3 ^ k1;
      x1 = p1[63:0];
      x3 = p0[63:0];
    end
    xs[0] = x0; xs[1] = x1; xs[2] = x2; xs[3] = x3;
    if ((x0 | x1 | x2 | x3) == 64'd0) xs[0] = 64'd1;
  endtask

  function automatic logic [63:0] rotl(input logic [63:0] v, input int n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // Advance the stream by one request and return the word it yields
  task automatic next_word(input logic restart, input logic [63:0] start,
                           output word_rec_t rec);
    logic [63:0] t;
    if (restart) begin
      cur_chunk = start;
      pos = 0;
      seed_chunk(cur_chunk);
    end
    rec.word = rotl(xs[0] + xs[3], 23) + xs[0];
    t = xs[1] << 17;
    xs[2] = xs[2] ^ xs[0];
    xs[3] = xs[3] ^ xs[1];
    xs[1] = xs[1] ^ xs[2];
    xs[0] = xs[0] ^ xs[3];
    xs[2] = xs[2] ^ t;
    xs[3] = rotl(xs[3], 45);
    rec.chunk_number  = cur_chunk;
    rec.last_in_chunk = (pos >= WORDS_PER_CHUNK - 1);
    if (rec.last_in_chunk) begin
      cur_chunk = cur_chunk + 64'd1;
      pos = 0;
      seed_chunk(cur_chunk);
    end else begin
      pos++;
    end
  endtask

  // One request transfer; called right after posedge clk
  task automatic send_req(input logic restart, input logic [63:0] start,
                          input logic typed = 1'b0, input logic [63:0] t_chunk = 64'd0,
                          input logic t_last = 1'b0);
    word_rec_t rec;
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.restart     <= restart;
    in_ch.start_chunk <= start;
    do @(posedge clk); while (!in_ch.ready);
    next_word(restart, start, rec);
    if (typed) begin
      rec.chunk_number  = t_chunk;
      rec.last_in_chunk = t_last;
    end
    pending_words.push_back(rec);
  endtask

  // Stop offering and wait until the core is idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SEED_SETTLE) @(posedge clk);
  endtask

  // One key write, with the write enable dropped low again before the task returns
  task automatic write_key(input logic idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_KEY_LOW) key_lo = val;
    else key_hi = val;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Restart segments: mostly short, some long enough to cross a chunk end
  task automatic run_segments(input int n_items);
    int          cnt;
    int          len;
    logic [63:0] start;
    cnt = 0;
    while (cnt < n_items) begin
      case ($urandom_range(0, 9))
        0, 1:    start = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1));
        2:       start = 64'($urandom_range(0, 3));
        default: start = rand64();
      endcase
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(510, 560) : $urandom_range(1, 40);
      if ($urandom_range(0, 7) == 0) send_req(1'b0, rand64());
      else send_req(1'b1, start);
      cnt++;
      for (int i = 1; i < len && cnt < n_items; i++) begin
        send_req(1'b0, rand64());
        cnt++;
      end
    end
  endtask

  // Output ready: random idling, or a counted hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  // Result check
  always @(posedge clk) begin
    word_rec_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.word, out_ch.chunk_number, out_ch.last_in_chunk};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word %h chunk %h last %b", got.word, got.chunk_number,
                   got.last_in_chunk);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp word %h chunk %h last %b, got word %h chunk %h last %b",
                     want.word, want.chunk_number, want.last_in_chunk,
                     got.word, got.chunk_number, got.last_in_chunk);
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    req_row_t rows[$];
    rows = '{
      '{1'b0, 64'd0,                  1'b1, 64'd0,                  1'b0},
      '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0,                  1'b0},
      '{1'b0, 64'h5555_5555_5555_5555, 1'b1, 64'd0,                  1'b0},
      '{1'b1, 64'd0,                  1'b1, 64'd0,                  1'b0},
      '{1'b1, 64'd0,                  1'b1, 64'd0,                  1'b0},
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
      '{1'b0, 64'd7,                  1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
      '{1'b1, 64'd1,                  1'b1, 64'd1,                  1'b0},
      '{1'b1, 64'h5555_5555_5555_5555, 1'b1, 64'h5555_5555_5555_5555, 1'b0},
      '{1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0},
      '{1'b0, 64'd0,                  1'b0, 64'd0,                  1'b0},
      '{1'b0, 64'd0,                  1'b0, 64'd0,                  1'b0},
      '{1'b0, 64'd0,                  1'b0, 64'd0,                  1'b0},
      '{1'b1, 64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000, 1'b0},
      '{1'b0, 64'd0,                  1'b0, 64'd0,                  1'b0},
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0},
      '{1'b0, 64'd0,                  1'b0, 64'd0,                  1'b0}
    };

    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_KEY_LOW; cfg_wdata = 64'd0;
    in_ch.valid = 1'b0; in_ch.restart = 1'b0; in_ch.start_chunk = 64'd0;
    out_ch.ready = 1'b0;
    mismatches = 0; quiet = 1'b0; hold_left = 0;
    key_lo = KEY_LOW_RST; key_hi = KEY_HIGH_RST;
    cur_chunk = 64'd0; pos = 0;
    seed_chunk(64'd0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset key
    foreach (rows[i])
      send_req(rows[i].restart, rows[i].start_chunk, rows[i].typed, rows[i].exp_chunk,
               rows[i].exp_last);
    drain();

    // All-zero key; key takes effect only at the next seeding
    write_key(CFG_KEY_LOW, 64'd0);
    write_key(CFG_KEY_HIGH, 64'd0);
    run_segments(300);
    drain();

    // All-ones key, no idling at all
    write_key(CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_key(CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    quiet = 1'b1;
    run_segments(250);
    drain();
    quiet = 1'b0;

    // Random key, with a long output hold-off while requests keep coming
    write_key(CFG_KEY_LOW, rand64());
    write_key(CFG_KEY_HIGH, rand64());
    @(negedge clk);
    hold_left = 300;
    @(posedge clk);
    run_segments(350);
    drain();

    // Random key again, only the high word changed
    write_key(CFG_KEY_HIGH, rand64());
    run_segments(400);

    in_ch.valid <= 1'b0;
    quiet = 1'b1;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SEED_SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
